### design/ddd_pkg.sv
// shared widths, constants and calendar tables for the date difference unit
package ddd_pkg;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  // largest year accepted as valid
  localparam int MAX_YEAR = 9999;
  localparam int YCMP_W   = 17;
  localparam logic [YCMP_W-1:0] MAX_YEAR_CMP = YCMP_W'(MAX_YEAR);

  // saturation value of the day count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // serial day number and day-of-year widths (sized for any 14-bit year)
  localparam int SER_W = 23;
  localparam int DOY_W = 9;

  // divide by 25 through a reciprocal multiply, exact for any 14-bit year
  localparam int DIV25_SHIFT = 19;
  localparam int MUL_W       = 15;
  localparam int PROD_W      = YEAR_W + MUL_W;
  localparam int Q_W         = PROD_W - DIV25_SHIFT;
  localparam logic [MUL_W-1:0] DIV25_MUL = MUL_W'((2 ** DIV25_SHIFT) / 25 + 1);
  localparam logic [YEAR_W-1:0] YEAR_25  = YEAR_W'(25);

  // month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // month shift so that the counting year starts in march
  localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd9;

  // length of a month in days
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of a month, months counted from march
  function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] ofs;
    case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

### design/ddd_in_if.sv
// input channel carrying a pair of dates
interface ddd_in_if;
  import ddd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

### design/ddd_out_if.sv
// output channel carrying the validity flag and the day count
interface ddd_out_if;
  import ddd_pkg::*;

  logic               valid;
  logic               ready;
  logic               dates_valid;
  logic [COUNT_W-1:0] day_count;

  modport source (
    output valid, dates_valid, day_count,
    input  ready
  );

  modport sink (
    input  valid, dates_valid, day_count,
    output ready
  );
endinterface

### design/date_difference_days_unit.sv
// top level: days between two gregorian dates, four-stage pipeline
//
//   port   | dir | handshake   | transaction
//   -------+-----+-------------+-------------------------------------------
//   in_i   | in  | valid/ready | two dates (day, month, year each)
//   out_o  | out | valid/ready | dates_valid flag and day_count
//
// one transaction per cycle sustained while out_o is ready; a result reaches the
// output register after passing through the four register stages
// (reciprocal divide, validity and year sum, serial day, difference)
// reset clears only the stage valid bits; payload registers are not reset
// a stall at the output holds each occupied stage with no empty stage after it; the rest keep filling
module date_difference_days_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ddd_in_if.sink    in_i,
  ddd_out_if.source out_o
);
  import ddd_pkg::*;

  // stage 1 contents for one date
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  yy;
    logic [Q_W-1:0]     q_y;
    logic [Q_W-1:0]     q_yy;
  } s1_t;

  // stage 2 contents for one date
  typedef struct packed {
    logic             ok;
    logic [SER_W-1:0] year_days;
    logic [DOY_W-1:0] doy;
  } s2_t;

  // pipeline enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 0: march-based year and divide by 25
  s1_t s1_d [2];
  s1_t s1_q [2];
  logic [DAY_W-1:0]   in_day   [2];
  logic [MONTH_W-1:0] in_month [2];
  logic [YEAR_W-1:0]  in_year  [2];
  logic [PROD_W-1:0]  prod_y   [2];
  logic [PROD_W-1:0]  prod_yy  [2];

  assign in_day[0]   = in_i.first_day;
  assign in_month[0] = in_i.first_month;
  assign in_year[0]  = in_i.first_year;
  assign in_day[1]   = in_i.second_day;
  assign in_month[1] = in_i.second_month;
  assign in_year[1]  = in_i.second_year;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s1_d[i].day   = in_day[i];
      s1_d[i].month = in_month[i];
      s1_d[i].year  = in_year[i];
      s1_d[i].yy    = (in_month[i] <= MONTH_FEB) ? in_year[i] - YEAR_W'(1) : in_year[i];
      prod_y[i]     = PROD_W'(in_year[i]) * PROD_W'(DIV25_MUL);
      prod_yy[i]    = PROD_W'(s1_d[i].yy) * PROD_W'(DIV25_MUL);
      s1_d[i].q_y   = prod_y[i][PROD_W-1:DIV25_SHIFT];
      s1_d[i].q_yy  = prod_yy[i][PROD_W-1:DIV25_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q[0] <= s1_d[0];
      s1_q[1] <= s1_d[1];
    end
  end

  // stage 1: leap rule, date check, days in whole years, day of year
  s2_t s2_d [2];
  s2_t s2_q [2];
  logic [YEAR_W-1:0]  rem25 [2];
  logic               leap  [2];
  logic [DAY_W-1:0]   mlen  [2];
  logic [MONTH_W-1:0] mp    [2];
  logic               y_ok  [2];
  logic               m_ok  [2];
  logic               d_ok  [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem25[i] = s1_q[i].year - YEAR_W'(s1_q[i].q_y) * YEAR_25;
      // divisible by 4 and not by 25, or by 16 and by 25
      leap[i]  = (s1_q[i].year[1:0] == 2'b00) &&
                 ((rem25[i] != '0) || (s1_q[i].year[3:0] == 4'b0000));
      mlen[i]  = month_days(s1_q[i].month, leap[i]);
      y_ok[i]  = (s1_q[i].year != '0) &&
                 ({(YCMP_W - YEAR_W)'(0), s1_q[i].year} <= MAX_YEAR_CMP);
      m_ok[i]  = (s1_q[i].month >= MONTH_JAN) && (s1_q[i].month <= MONTH_DEC);
      d_ok[i]  = (s1_q[i].day != '0) && (s1_q[i].day <= mlen[i]);
      s2_d[i].ok = y_ok[i] && m_ok[i] && d_ok[i];
      mp[i]    = (s1_q[i].month >= MONTH_MAR) ? s1_q[i].month - MONTH_MAR
                                              : s1_q[i].month + MONTH_WRAP;
      s2_d[i].doy = month_offset(mp[i]) + DOY_W'(s1_q[i].day) - DOY_W'(1);
      // 365*yy + yy/4 - yy/100 + yy/400
      s2_d[i].year_days = SER_W'(s1_q[i].yy) * SER_W'(365)
                        + SER_W'(s1_q[i].yy >> 2)
                        + SER_W'(s1_q[i].q_yy >> 4)
                        - SER_W'(s1_q[i].q_yy >> 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q[0] <= s2_d[0];
      s2_q[1] <= s2_d[1];
    end
  end

  // stage 2: serial day numbers
  logic [SER_W-1:0] ser_d [2];
  logic [SER_W-1:0] ser_q [2];
  logic             ok3_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ser_d[i] = s2_q[i].year_days + SER_W'(s2_q[i].doy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ser_q[0] <= ser_d[0];
      ser_q[1] <= ser_d[1];
      ok3_q    <= s2_q[0].ok && s2_q[1].ok;
    end
  end

  // stage 3: absolute difference, saturation and invalid masking
  logic [SER_W:0]     diff_ab;
  logic [SER_W-1:0]   diff_abs;
  logic [COUNT_W-1:0] count_d;
  logic [COUNT_W-1:0] count_q;
  logic               dvalid_q;

  always_comb begin
    diff_ab  = {1'b0, ser_q[0]} - {1'b0, ser_q[1]};
    diff_abs = diff_ab[SER_W] ? ser_q[1] - ser_q[0] : diff_ab[SER_W-1:0];
    if (!ok3_q) begin
      count_d = '0;
    end else if (diff_abs > SER_W'(COUNT_MAX)) begin
      count_d = COUNT_MAX;
    end else begin
      count_d = diff_abs[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      count_q  <= count_d;
      dvalid_q <= ok3_q;
    end
  end

  // output register drives the channel
  assign out_o.valid       = v4_q;
  assign out_o.dates_valid = dvalid_q;
  assign out_o.day_count   = count_q;

endmodule
